FILE: rtl/lob_pkg.sv
package lob_pkg;

   // fixed field widths
   localparam int ID_W    = 10;
   localparam int PRICE_W = 12;
   localparam int QTY_W   = 20;
   localparam int TOTAL_W = QTY_W + ID_W;
   localparam int STAT_W  = 3;

   // defaults for the top level parameters
   localparam int ORDER_SLOTS_DEF   = 1024;
   localparam int LEVEL_SLOTS_DEF   = 256;
   localparam int PRICE_TICKS_DEF   = 4096;
   localparam int QUANTITY_BITS_DEF = 20;

   // cells per first stage of the search tree
   localparam int REDUCE_GROUP = 16;

   // operation codes
   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_CANCEL = 2'd1;
   localparam logic [1:0] OP_MODIFY = 2'd2;

   // status codes
   localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
   localparam logic [STAT_W-1:0] ST_UNKNOWN  = 3'd1;
   localparam logic [STAT_W-1:0] ST_INVALID  = 3'd2;
   localparam logic [STAT_W-1:0] ST_ID_INUSE = 3'd3;
   localparam logic [STAT_W-1:0] ST_NO_LEVEL = 3'd4;

   typedef enum logic [1:0] {
      CMD_NONE,
      CMD_INSERT,
      CMD_REMOVE,
      CMD_UPDATE
   } cmd_op_type;

   // one price level as held by a cell
   typedef struct packed {
      logic               valid;
      logic [PRICE_W-1:0] price;
      logic [TOTAL_W-1:0] total;
      logic [ID_W-1:0]    head;
      logic [ID_W-1:0]    tail;
   } level_type;

   // command broadcast to every cell of one side
   typedef struct packed {
      cmd_op_type         op;
      logic               is_buy;
      logic [PRICE_W-1:0] price;
      logic [TOTAL_W-1:0] total;
      logic [ID_W-1:0]    head;
      logic [ID_W-1:0]    tail;
   } cmd_type;

   // level found by a price search
   typedef struct packed {
      logic               hit;
      logic [TOTAL_W-1:0] total;
      logic [ID_W-1:0]    head;
      logic [ID_W-1:0]    tail;
   } search_type;

   // order queue link, none set means end of queue
   typedef struct packed {
      logic            none;
      logic [ID_W-1:0] id;
   } link_type;

   typedef struct packed {
      logic               live;
      logic               side;
      logic [PRICE_W-1:0] limit;
      logic [QTY_W-1:0]   amount;
   } info_type;

endpackage

FILE: rtl/lob_ram.sv
module lob_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/lob_level_cell.sv
module lob_level_cell
   import lob_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  cmd_type   cmd,
   input  level_type prev_level,   // better neighbor
   input  level_type next_level,   // worse neighbor
   input  logic      better_in,    // better neighbor keeps its place on insert
   output logic      better_out,
   output level_type level
);

   level_type level_ff;
   logic      own_better;
   logic      own_hit;

   // this cell ranks ahead of the command price
   assign own_better = level_ff.valid &&
                       (cmd.is_buy ? (level_ff.price > cmd.price) :
                                     (level_ff.price < cmd.price));
   assign own_hit    = level_ff.valid && (level_ff.price == cmd.price);

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
      end else begin
         unique case (cmd.op)
            CMD_INSERT: begin
               if (!own_better) begin
                  if (better_in) begin
                     level_ff.valid <= 1'b1;
                     level_ff.price <= cmd.price;
                     level_ff.total <= cmd.total;
                     level_ff.head  <= cmd.head;
                     level_ff.tail  <= cmd.tail;
                  end else begin
                     level_ff <= prev_level;
                  end
               end
            end
            CMD_REMOVE: begin
               // the removed level and everything worse close up
               if (!own_better) begin
                  level_ff <= next_level;
               end
            end
            CMD_UPDATE: begin
               if (own_hit) begin
                  level_ff.total <= cmd.total;
                  level_ff.head  <= cmd.head;
                  level_ff.tail  <= cmd.tail;
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign better_out = own_better;
   assign level      = level_ff;

endmodule

FILE: rtl/lob_level_chain.sv
module lob_level_chain
   import lob_pkg::*;
#(
   parameter int DEPTH = LEVEL_SLOTS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   input  logic [PRICE_W-1:0] key_price,
   output search_type         found,
   output level_type          top_level
);

   localparam int GROUPS = (DEPTH + REDUCE_GROUP - 1) / REDUCE_GROUP;

   level_type  levels [DEPTH];
   logic       better [DEPTH];
   search_type part_in [GROUPS];
   search_type part_ff [GROUPS];
   search_type found_in;
   search_type found_ff;

   // row of cells, best level at index zero
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      level_type prev_w;
      level_type next_w;
      logic      bin_w;
      if (i == 0) begin : g_first
         assign prev_w = '0;
         assign bin_w  = 1'b1;
      end else begin : g_inner
         assign prev_w = levels[i-1];
         assign bin_w  = better[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign next_w = '0;
      end else begin : g_more
         assign next_w = levels[i+1];
      end
      lob_level_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .prev_level (prev_w),
         .next_level (next_w),
         .better_in  (bin_w),
         .better_out (better[i]),
         .level      (levels[i])
      );
   end

   // first search stage: one hit per group of cells
   always_comb begin
      int idx;
      for (int g = 0; g < GROUPS; g++) begin
         part_in[g] = '0;
         for (int k = 0; k < REDUCE_GROUP; k++) begin
            idx = g * REDUCE_GROUP + k;
            if (idx < DEPTH) begin
               if (levels[idx].valid && (levels[idx].price == key_price)) begin
                  part_in[g].hit   = 1'b1;
                  part_in[g].total = part_in[g].total | levels[idx].total;
                  part_in[g].head  = part_in[g].head  | levels[idx].head;
                  part_in[g].tail  = part_in[g].tail  | levels[idx].tail;
               end
            end
         end
      end
   end

   // second search stage: merge the groups, prices are unique per side
   always_comb begin
      found_in = '0;
      for (int g = 0; g < GROUPS; g++) begin
         found_in = found_in | part_ff[g];
      end
   end

   always_ff @(posedge clock) begin
      part_ff  <= part_in;
      found_ff <= found_in;
   end

   assign found     = found_ff;
   assign top_level = levels[0];

endmodule

FILE: rtl/limit_order_book_maintenance_core.sv
// One item at a time: req_tready is high only while idle. Each item goes through
// the order table read, a two-stage price search over the level cells, then the
// level update and queue link writes. A held-off result stalls the next item
// until it is taken.
// Reset: synchronous; levels empty at once, then a clearing pass clears the info
// of all ORDER_SLOTS order table entries (1024 by default) with req_tready low.
module limit_order_book_maintenance_core
   import lob_pkg::*;
#(
   parameter int ORDER_SLOTS   = ORDER_SLOTS_DEF,
   parameter int LEVEL_SLOTS   = LEVEL_SLOTS_DEF,
   parameter int PRICE_TICKS   = PRICE_TICKS_DEF,
   parameter int QUANTITY_BITS = QUANTITY_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // order_id[9:0], is_buy[10], price[22:11], quantity[42:23], zero fill
   input  logic [47:0] req_tdata,
   // operation[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // resubmit[0], resubmit_price[12:1], resubmit_quantity[32:13],
   // resubmit_is_buy[33], best_bid_valid[34], best_bid_price[46:35],
   // best_bid_order[56:47], best_ask_valid[57], best_ask_price[69:58],
   // best_ask_order[79:70]
   output logic [79:0] rsp_tdata,
   // status[2:0]
   output logic [2:0]  rsp_tuser
);

   localparam int AW    = $clog2(ORDER_SLOTS);
   localparam int CNT_W = $clog2(LEVEL_SLOTS + 1);
   localparam logic [QTY_W-1:0] QTY_MASK = QTY_W'((64'd1 << QUANTITY_BITS) - 64'd1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(LEVEL_SLOTS);
   localparam link_type LINK_NONE = '{none: 1'b1, id: '0};

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_READ, S_SEARCH1, S_SEARCH2, S_EXEC, S_EXEC2
   } state_type;

   typedef enum logic [1:0] {
      ACT_NONE, ACT_ADD, ACT_CANCEL, ACT_MODQ
   } act_type;

   state_type          state_ff;
   logic [AW-1:0]      clear_idx_ff;
   logic [1:0]         op_ff;
   logic [ID_W-1:0]    id_ff;
   logic               side_ff;
   logic [PRICE_W-1:0] price_ff;
   logic [QTY_W-1:0]   qty_ff;
   act_type            act_ff;
   logic [STAT_W-1:0]  status_ff;
   logic               rs_ff;
   logic               rs_side_ff;
   info_type           info_ff;
   link_type           newer_ff;
   link_type           older_ff;
   logic [PRICE_W-1:0] key_price_ff;
   logic               key_side_ff;
   logic [ID_W-1:0]    tail_ff;
   logic               tail_link_ff;
   logic [CNT_W-1:0]   level_count_ff;
   logic               rsp_valid_ff;
   logic [79:0]        rsp_data_ff;
   logic [2:0]         rsp_user_ff;

   // order table ports
   logic          info_we, newer_we, older_we;
   logic [AW-1:0] info_wa, newer_wa, older_wa, rd_addr;
   info_type      info_wd, info_rd;
   link_type      newer_wd, newer_rd, older_wd, older_rd;

   // level chains
   cmd_type    cmd, bid_cmd, ask_cmd;
   search_type bid_found, ask_found, sel;
   level_type  bid_top, ask_top;

   logic               accept;
   logic               price_ok;
   logic               id_ok;
   logic               room;
   logic [TOTAL_W-1:0] amt_w, qty_w, take_w;

   assign accept   = req_tvalid && req_tready;
   assign price_ok = (price_ff != '0) && (32'(price_ff) < PRICE_TICKS);
   assign id_ok    = 32'(id_ff) < ORDER_SLOTS;
   assign sel      = key_side_ff ? bid_found : ask_found;
   assign room     = level_count_ff < CNT_FULL;
   assign amt_w    = TOTAL_W'(info_ff.amount);
   assign qty_w    = TOTAL_W'(qty_ff);
   assign take_w   = (amt_w <= sel.total) ? amt_w : sel.total;
   assign rd_addr  = (state_ff == S_IDLE) ? AW'(req_tdata[9:0]) : AW'(id_ff);

   // table writes and level commands
   always_comb begin
      info_we  = 1'b0;
      info_wa  = AW'(id_ff);
      info_wd  = '0;
      newer_we = 1'b0;
      newer_wa = AW'(id_ff);
      newer_wd = LINK_NONE;
      older_we = 1'b0;
      older_wa = AW'(id_ff);
      older_wd = LINK_NONE;
      cmd        = '0;
      cmd.op     = CMD_NONE;
      cmd.is_buy = key_side_ff;
      cmd.price  = key_price_ff;
      cmd.head   = sel.head;
      cmd.tail   = sel.tail;
      cmd.total  = sel.total;
      unique case (state_ff)
         S_CLEAR: begin
            info_we = 1'b1;
            info_wa = clear_idx_ff;
         end
         S_EXEC: begin
            unique case (act_ff)
               ACT_ADD: begin
                  if (sel.hit || room) begin
                     info_we  = 1'b1;
                     info_wd  = '{live: 1'b1, side: side_ff, limit: price_ff,
                                  amount: qty_ff};
                     newer_we = 1'b1;
                     older_we = 1'b1;
                     if (sel.hit) begin
                        older_wd  = '{none: 1'b0, id: sel.tail};
                        cmd.op    = CMD_UPDATE;
                        cmd.tail  = id_ff;
                        cmd.total = sel.total + qty_w;
                     end else begin
                        cmd.op    = CMD_INSERT;
                        cmd.head  = id_ff;
                        cmd.tail  = id_ff;
                        cmd.total = qty_w;
                     end
                  end
               end
               ACT_CANCEL: begin
                  info_we      = 1'b1;
                  info_wd      = info_ff;
                  info_wd.live = 1'b0;
                  if (sel.hit) begin
                     newer_we = !older_ff.none;
                     newer_wa = AW'(older_ff.id);
                     newer_wd = newer_ff;
                     older_we = !newer_ff.none;
                     older_wa = AW'(newer_ff.id);
                     older_wd = older_ff;
                     if (older_ff.none && newer_ff.none) begin
                        cmd.op = CMD_REMOVE;
                     end else begin
                        cmd.op    = CMD_UPDATE;
                        cmd.head  = older_ff.none ? newer_ff.id : sel.head;
                        cmd.tail  = newer_ff.none ? older_ff.id : sel.tail;
                        cmd.total = sel.total - take_w;
                     end
                  end
               end
               ACT_MODQ: begin
                  info_we        = 1'b1;
                  info_wd        = info_ff;
                  info_wd.amount = qty_ff;
                  if (sel.hit) begin
                     cmd.op    = CMD_UPDATE;
                     cmd.total = sel.total - amt_w + qty_w;
                  end
               end
               default: begin
               end
            endcase
         end
         S_EXEC2: begin
            // link the previous tail to the appended order
            newer_we = tail_link_ff;
            newer_wa = AW'(tail_ff);
            newer_wd = '{none: 1'b0, id: id_ff};
         end
         default: begin
         end
      endcase
      bid_cmd = cmd;
      ask_cmd = cmd;
      if (key_side_ff) begin
         ask_cmd.op = CMD_NONE;
      end else begin
         bid_cmd.op = CMD_NONE;
      end
   end

   // sequencer and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         clear_idx_ff   <= '0;
         level_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
         tail_link_ff   <= 1'b0;
         act_ff         <= ACT_NONE;
      end else begin
         // the final step reloads the result register itself
         if (rsp_valid_ff && rsp_tready && (state_ff != S_EXEC2)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_CLEAR: begin
               clear_idx_ff <= clear_idx_ff + 1'b1;
               if (clear_idx_ff == AW'(ORDER_SLOTS - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (accept) begin
                  op_ff    <= req_tuser;
                  id_ff    <= req_tdata[9:0];
                  side_ff  <= req_tdata[10];
                  price_ff <= req_tdata[22:11];
                  qty_ff   <= req_tdata[42:23] & QTY_MASK;
                  state_ff <= S_READ;
               end
            end
            S_READ: begin
               info_ff      <= info_rd;
               newer_ff     <= newer_rd;
               older_ff     <= older_rd;
               rs_ff        <= 1'b0;
               rs_side_ff   <= 1'b0;
               act_ff       <= ACT_NONE;
               status_ff    <= ST_OK;
               key_price_ff <= (op_ff == OP_ADD) ? price_ff : info_rd.limit;
               key_side_ff  <= (op_ff == OP_ADD) ? side_ff : info_rd.side;
               priority if (op_ff != OP_ADD && op_ff != OP_CANCEL && op_ff != OP_MODIFY) begin
                  status_ff <= ST_INVALID;
               end else if (!id_ok) begin
                  status_ff <= ST_UNKNOWN;
               end else if (op_ff == OP_ADD) begin
                  if (!price_ok || qty_ff == '0) begin
                     status_ff <= ST_INVALID;
                  end else if (info_rd.live) begin
                     status_ff <= ST_ID_INUSE;
                  end else begin
                     act_ff <= ACT_ADD;
                  end
               end else if (!info_rd.live) begin
                  status_ff <= ST_UNKNOWN;
               end else if (op_ff == OP_CANCEL) begin
                  act_ff <= ACT_CANCEL;
               end else if (!price_ok) begin
                  status_ff <= ST_INVALID;
               end else if (qty_ff == '0) begin
                  act_ff <= ACT_CANCEL;
               end else if (price_ff == info_rd.limit) begin
                  act_ff <= ACT_MODQ;
               end else begin
                  // price change: cancel and hand the order back
                  act_ff     <= ACT_CANCEL;
                  rs_ff      <= 1'b1;
                  rs_side_ff <= info_rd.side;
               end
               state_ff <= S_SEARCH1;
            end
            S_SEARCH1: begin
               state_ff <= S_SEARCH2;
            end
            S_SEARCH2: begin
               state_ff <= S_EXEC;
            end
            S_EXEC: begin
               tail_ff      <= sel.tail;
               tail_link_ff <= (act_ff == ACT_ADD) && sel.hit;
               if (act_ff == ACT_ADD && !sel.hit) begin
                  if (room) begin
                     level_count_ff <= level_count_ff + 1'b1;
                  end else begin
                     status_ff <= ST_NO_LEVEL;
                  end
               end else if (cmd.op == CMD_REMOVE) begin
                  level_count_ff <= level_count_ff - 1'b1;
               end
               state_ff <= S_EXEC2;
            end
            S_EXEC2: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff       <= 1'b1;
                  rsp_user_ff        <= status_ff;
                  rsp_data_ff[0]     <= rs_ff;
                  rsp_data_ff[12:1]  <= rs_ff ? price_ff : '0;
                  rsp_data_ff[32:13] <= rs_ff ? qty_ff : '0;
                  rsp_data_ff[33]    <= rs_side_ff;
                  rsp_data_ff[34]    <= bid_top.valid;
                  rsp_data_ff[46:35] <= bid_top.valid ? bid_top.price : '0;
                  rsp_data_ff[56:47] <= bid_top.valid ? bid_top.head : '0;
                  rsp_data_ff[57]    <= ask_top.valid;
                  rsp_data_ff[69:58] <= ask_top.valid ? ask_top.price : '0;
                  rsp_data_ff[79:70] <= ask_top.valid ? ask_top.head : '0;
                  tail_link_ff       <= 1'b0;
                  state_ff           <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // order table: info, newer link and older link
   lob_ram #(.WIDTH($bits(info_type)), .DEPTH(ORDER_SLOTS)) u_info (
      .clock   (clock),
      .wr_en   (info_we),
      .wr_addr (info_wa),
      .wr_data (info_wd),
      .rd_addr (rd_addr),
      .rd_data (info_rd)
   );

   lob_ram #(.WIDTH($bits(link_type)), .DEPTH(ORDER_SLOTS)) u_newer (
      .clock   (clock),
      .wr_en   (newer_we),
      .wr_addr (newer_wa),
      .wr_data (newer_wd),
      .rd_addr (rd_addr),
      .rd_data (newer_rd)
   );

   lob_ram #(.WIDTH($bits(link_type)), .DEPTH(ORDER_SLOTS)) u_older (
      .clock   (clock),
      .wr_en   (older_we),
      .wr_addr (older_wa),
      .wr_data (older_wd),
      .rd_addr (rd_addr),
      .rd_data (older_rd)
   );

   // sorted price levels per side
   lob_level_chain #(.DEPTH(LEVEL_SLOTS)) u_bid (
      .clock     (clock),
      .reset     (reset),
      .cmd       (bid_cmd),
      .key_price (key_price_ff),
      .found     (bid_found),
      .top_level (bid_top)
   );

   lob_level_chain #(.DEPTH(LEVEL_SLOTS)) u_ask (
      .clock     (clock),
      .reset     (reset),
      .cmd       (ask_cmd),
      .key_price (key_price_ff),
      .found     (ask_found),
      .top_level (ask_top)
   );

   // level count never exceeds the pool
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      level_count_ff <= CNT_FULL)
      else $error("level count above pool size");

   // no level allocated without room in the pool
   a_insert_room : assert property (@(posedge clock) disable iff (reset)
      (bid_cmd.op == CMD_INSERT || ask_cmd.op == CMD_INSERT) |-> room)
      else $error("level insert with pool full");

   // an empty pool means both sides are empty
   a_empty_book : assert property (@(posedge clock) disable iff (reset)
      (level_count_ff == '0) |-> (!bid_top.valid && !ask_top.valid))
      else $error("best level present with no levels allocated");

   // a result only comes out of the final step
   a_rsp_source : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> ($past(state_ff) == S_EXEC2))
      else $error("result raised outside final step");

endmodule

FILE: bench/tb_top.sv
module tb_top;
   import lob_pkg::*;

   localparam int NORDERS = 1024;
   localparam int NLEVELS = 256;
   localparam int NTICKS  = 4096;
   localparam int NONE_O  = NORDERS;
   localparam int NONE_L  = NLEVELS;
   localparam int N_RANDOM = 1414;
   localparam longint CYCLE_LIMIT = 400000;

   // one request item
   typedef struct packed {
      logic [1:0]  op;
      logic [9:0]  id;
      logic        buy;
      logic [11:0] price;
      logic [19:0] qty;
   } order_req_t;

   // one book snapshot as returned by the block
   typedef struct packed {
      logic [2:0]  status;
      logic        resub;
      logic [11:0] resub_price;
      logic [19:0] resub_qty;
      logic        resub_buy;
      logic        bid_valid;
      logic [11:0] bid_price;
      logic [9:0]  bid_order;
      logic        ask_valid;
      logic [11:0] ask_price;
      logic [9:0]  ask_order;
   } book_rsp_t;

   // shadow book with price-time priority, plus the queue of expected snapshots
   class book_scoreboard;
      bit          live[NORDERS];
      bit          side[NORDERS];
      int          lim[NORDERS];
      longint      amt[NORDERS];
      int          newer[NORDERS];
      int          older[NORDERS];
      int          lvl_of[2*NTICKS];
      int          lv_price[NLEVELS];
      bit          lv_buy[NLEVELS];
      longint      lv_total[NLEVELS];
      int          lv_head[NLEVELS];
      int          lv_tail[NLEVELS];
      int          lv_better[NLEVELS];
      int          lv_worse[NLEVELS];
      int          bid_top, ask_top;
      int          free_stack[NLEVELS];
      int          free_cnt;
      book_rsp_t   pending[$];
      int          errors;

      function new();
         for (int i = 0; i < NLEVELS; i++) free_stack[i] = i;
         free_cnt = NLEVELS;
         bid_top = NONE_L;
         ask_top = NONE_L;
      endfunction

      function int key(bit s, int p);
         return s * NTICKS + p;
      endfunction

      function void drop_level(int lv);
         int b, w;
         b = lv_better[lv];
         w = lv_worse[lv];
         lvl_of[key(lv_buy[lv], lv_price[lv])] = 0;
         if (b != NONE_L) lv_worse[b] = w;
         else if (lv_buy[lv]) bid_top = w;
         else ask_top = w;
         if (w != NONE_L) lv_better[w] = b;
         if (free_cnt < NLEVELS) free_stack[free_cnt++] = lv;
      endfunction

      function void unlink_order(int id);
         int m, lv;
         m = lvl_of[key(side[id], lim[id])];
         live[id] = 0;
         if (m == 0) return;
         lv = m - 1;
         if (older[id] != NONE_O) newer[older[id]] = newer[id];
         else lv_head[lv] = newer[id];
         if (newer[id] != NONE_O) older[newer[id]] = older[id];
         else lv_tail[lv] = older[id];
         lv_total[lv] -= (amt[id] <= lv_total[lv]) ? amt[id] : lv_total[lv];
         if (lv_head[lv] == NONE_O) drop_level(lv);
      endfunction

      // walk the side list best first and link the new level in
      function void link_level(int lv);
         int prv, walk;
         bit b;
         b = lv_buy[lv];
         prv = NONE_L;
         walk = b ? bid_top : ask_top;
         while (walk != NONE_L &&
                (b ? lv_price[walk] > lv_price[lv] : lv_price[walk] < lv_price[lv])) begin
            prv = walk;
            walk = lv_worse[walk];
         end
         lv_better[lv] = prv;
         lv_worse[lv] = walk;
         if (prv == NONE_L) begin
            if (b) bid_top = lv; else ask_top = lv;
         end else lv_worse[prv] = lv;
         if (walk != NONE_L) lv_better[walk] = lv;
      endfunction

      function logic [2:0] place_order(int id, bit s, int p, longint q);
         int k, lv;
         k = key(s, p);
         if (lvl_of[k] == 0) begin
            if (free_cnt == 0) return ST_NO_LEVEL;
            lv = free_stack[--free_cnt];
            lv_price[lv] = p;
            lv_buy[lv] = s;
            lv_total[lv] = 0;
            lv_head[lv] = NONE_O;
            lv_tail[lv] = NONE_O;
            lvl_of[k] = lv + 1;
            link_level(lv);
         end else lv = lvl_of[k] - 1;
         live[id] = 1;
         side[id] = s;
         lim[id] = p;
         amt[id] = q;
         newer[id] = NONE_O;
         older[id] = lv_tail[lv];
         if (lv_tail[lv] != NONE_O) newer[lv_tail[lv]] = id;
         else lv_head[lv] = id;
         lv_tail[lv] = id;
         lv_total[lv] += q;
         return ST_OK;
      endfunction

      // note an accepted request and queue the snapshot it must produce
      function void note_request(order_req_t r);
         book_rsp_t e;
         int id, p, lv;
         bit pok;
         longint q;
         e = '0;
         id = int'(r.id);
         p = int'(r.price);
         q = longint'(r.qty);
         pok = (p != 0);
         e.status = ST_OK;
         if (r.op == 2'd3) e.status = ST_INVALID;
         else if (r.op == OP_ADD) begin
            if (!pok || q == 0) e.status = ST_INVALID;
            else if (live[id]) e.status = ST_ID_INUSE;
            else e.status = place_order(id, r.buy, p, q);
         end else if (!live[id]) e.status = ST_UNKNOWN;
         else if (r.op == OP_CANCEL) unlink_order(id);
         else if (!pok) e.status = ST_INVALID;
         else if (q == 0) unlink_order(id);
         else if (p == lim[id]) begin
            if (lvl_of[key(side[id], p)] != 0) begin
               lv = lvl_of[key(side[id], p)] - 1;
               lv_total[lv] = lv_total[lv] - amt[id] + q;
            end
            amt[id] = q;
         end else begin
            e.resub_buy = side[id];
            unlink_order(id);
            e.resub = 1;
            e.resub_price = r.price;
            e.resub_qty = r.qty;
         end
         if (bid_top != NONE_L) begin
            e.bid_valid = 1;
            e.bid_price = 12'(lv_price[bid_top]);
            e.bid_order = 10'(lv_head[bid_top]);
         end
         if (ask_top != NONE_L) begin
            e.ask_valid = 1;
            e.ask_price = 12'(lv_price[ask_top]);
            e.ask_order = 10'(lv_head[ask_top]);
         end
         pending.push_back(e);
      endfunction

      function void check_snapshot(book_rsp_t a);
         book_rsp_t e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected response status=%0d", $time, a.status);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (a !== e) begin
            $display("%0t: mismatch exp st=%0d rs=%0b/%0d/%0d/%0b bid=%0b/%0d/%0d ask=%0b/%0d/%0d",
                     $time, e.status, e.resub, e.resub_price, e.resub_qty, e.resub_buy,
                     e.bid_valid, e.bid_price, e.bid_order,
                     e.ask_valid, e.ask_price, e.ask_order);
            $display("%0t:          got st=%0d rs=%0b/%0d/%0d/%0b bid=%0b/%0d/%0d ask=%0b/%0d/%0d",
                     $time, a.status, a.resub, a.resub_price, a.resub_qty, a.resub_buy,
                     a.bid_valid, a.bid_price, a.bid_order,
                     a.ask_valid, a.ask_price, a.ask_order);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [79:0] rsp_tdata;
   logic [2:0]  rsp_tuser;

   book_scoreboard book;
   longint cycle_count = 0;
   bit     hold_rsp = 0;

   limit_order_book_maintenance_core u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   always #5 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // note accepted requests straight from the bus
   always @(posedge clock) begin
      order_req_t q;
      if (!reset && req_tvalid && req_tready) begin
         q.op    = req_tuser;
         q.id    = req_tdata[9:0];
         q.buy   = req_tdata[10];
         q.price = req_tdata[22:11];
         q.qty   = req_tdata[42:23];
         book.note_request(q);
      end
   end

   // check accepted responses
   always @(posedge clock) begin
      book_rsp_t a;
      if (!reset && rsp_tvalid && rsp_tready) begin
         a.status      = rsp_tuser;
         a.resub       = rsp_tdata[0];
         a.resub_price = rsp_tdata[12:1];
         a.resub_qty   = rsp_tdata[32:13];
         a.resub_buy   = rsp_tdata[33];
         a.bid_valid   = rsp_tdata[34];
         a.bid_price   = rsp_tdata[46:35];
         a.bid_order   = rsp_tdata[56:47];
         a.ask_valid   = rsp_tdata[57];
         a.ask_price   = rsp_tdata[69:58];
         a.ask_order   = rsp_tdata[79:70];
         book.check_snapshot(a);
      end
   end

   // response side: random stalls, one long hold-off while requests keep coming
   initial begin
      int gap;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_tready <= 0;
            repeat (300) @(posedge clock);
            hold_rsp = 0;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
         if (gap > 0) begin
            rsp_tready <= 0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1;
      end
   end

   task automatic send_req(order_req_t r);
      int gap;
      gap = $urandom_range(0, 5);
      if (gap > 0 && $urandom_range(0, 2) != 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= r.op;
      req_tdata <= {5'd0, r.qty, r.price, r.buy, r.id};
      do @(posedge clock); while (!req_tready);
   endtask

   function automatic order_req_t mk(logic [1:0] op, int id, bit b, int p, int q);
      order_req_t r;
      r.op = op; r.id = 10'(id); r.buy = b; r.price = 12'(p); r.qty = 20'(q);
      return r;
   endfunction

   // random request, mostly well formed, ids mostly from a small set, prices from base to base + span
   function automatic order_req_t rand_req(int base, int span);
      order_req_t r;
      int sel;
      sel = $urandom_range(0, 99);
      r.id = (sel < 90) ? 10'($urandom_range(0, 63)) : 10'($urandom_range(0, 1023));
      r.buy = 1'($urandom_range(0, 1));
      r.price = 12'(base + int'($urandom_range(0, span)));
      r.qty = ($urandom_range(0, 9) == 0) ? 20'($urandom) : 20'($urandom_range(1, 1000));
      sel = $urandom_range(0, 99);
      if (sel < 50) r.op = OP_ADD;
      else if (sel < 70) r.op = OP_CANCEL;
      else if (sel < 97) r.op = OP_MODIFY;
      else r.op = 2'd3;
      if ($urandom_range(0, 29) == 0) r.price = '0;
      if ($urandom_range(0, 29) == 0) r.qty = '0;
      return r;
   endfunction

   initial begin
      order_req_t r;
      int wait_cnt;
      book = new();
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: extremes, every op, error paths
      send_req(mk(OP_ADD, 0, 1, 100, 5));
      send_req(mk(OP_ADD, 1023, 1, 4095, 20'hFFFFF));
      send_req(mk(OP_ADD, 2, 0, 1, 7));
      send_req(mk(OP_ADD, 3, 0, 4095, 9));
      send_req(mk(OP_ADD, 4, 1, 100, 3));
      send_req(mk(OP_ADD, 5, 0, 0, 3));
      send_req(mk(OP_ADD, 5, 0, 10, 0));
      send_req(mk(OP_ADD, 0, 0, 200, 1));
      send_req(mk(OP_ADD, 6, 1, 1, 1));
      send_req(mk(OP_ADD, 7, 0, 4095, 2));
      send_req(mk(OP_CANCEL, 9, 0, 0, 0));
      send_req(mk(OP_MODIFY, 9, 1, 10, 10));
      send_req(mk(OP_MODIFY, 0, 0, 0, 10));
      send_req(mk(OP_MODIFY, 0, 0, 100, 50));
      send_req(mk(OP_MODIFY, 1023, 0, 50, 20'hFFFFF));
      send_req(mk(OP_MODIFY, 4, 1, 100, 0));
      send_req(mk(OP_CANCEL, 2, 1, 4095, 20'hFFFFF));
      send_req(mk(2'd3, 1023, 1, 4095, 20'hFFFFF));
      send_req(mk(OP_CANCEL, 0, 0, 0, 0));
      send_req(mk(OP_MODIFY, 3, 1, 3000, 77));
      send_req(mk(OP_CANCEL, 6, 0, 0, 0));
      send_req(mk(OP_CANCEL, 7, 0, 0, 0));

      // fill every level, then hit the no-free-level case, then drain
      for (int i = 0; i < 257; i++) send_req(mk(OP_ADD, 100 + i, 1'(i & 1), 1000 + i, 1));
      send_req(mk(OP_ADD, 400, 0, 3999, 1));
      for (int i = 0; i < 256; i++) send_req(mk(OP_CANCEL, 100 + i, 0, 0, 0));

      // random phases, one with a long response hold-off
      for (int i = 0; i < N_RANDOM; i++) begin
         if (i == 400) hold_rsp = 1;
         if (i < 1000) r = rand_req(2000, 40);
         else r = rand_req(1, 4094);
         send_req(r);
      end
      req_tvalid <= 0;

      wait_cnt = 0;
      while (book.pending.size() != 0 && wait_cnt < 20000) begin
         @(posedge clock);
         wait_cnt++;
      end
      repeat (20) @(posedge clock);
      if (book.errors == 0 && book.pending.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule

FILE: filelist.f
rtl/lob_pkg.sv
rtl/lob_ram.sv
rtl/lob_level_cell.sv
rtl/lob_level_chain.sv
rtl/limit_order_book_maintenance_core.sv
bench/tb_top.sv
